[sv/stidi_pkg.sv]
// Shared types and codes for the sorted table block.
// No dependencies; used by the top level and by its checker.
package stidi_pkg;

   localparam int DATA_W = 32;

   // operation codes of a request
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // status codes of a response
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DELETED   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_INVALID   = 3'd6;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [DATA_W-1:0] value;
      logic [4:0]               position;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [DATA_W-1:0] read_value;
      logic [4:0]               entry_count;
   } rsp_type;

endpackage

[sv/stidi_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module stidi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sorted_table_insert_delete_index.sv]
// Sorted table of up to CAPACITY signed 32-bit entries held in ascending order in one RAM
// (duplicates allowed, a new value goes after equal entries). A request is insert, delete of
// the first entry equal to the key, or read by 1-based position; each gives one response
// with a status and the entry count after the operation. Requests are handled one at a time.
// The table moves one entry per cycle through the RAM's single write port. An insert or delete
// walks the table, a read takes one RAM read, and a request that needs no RAM access goes
// straight to the response; the next request is taken in the cycle the response appears. The
// block takes the next request while a response waits in the output register. No clearing
// pass is needed after reset.
// Depends on stidi_pkg and stidi_ram.
module sorted_table_insert_delete_index #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stidi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stidi_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_INS  = 5'b00010,
      S_DEL  = 5'b00100,
      S_RD   = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic pend_ff, pend_in;
   logic found_ff, found_in;
   logic signed [stidi_pkg::DATA_W-1:0] key_ff, key_in;
   logic [2:0] res_status_ff, res_status_in;
   logic signed [stidi_pkg::DATA_W-1:0] res_value_ff, res_value_in;
   logic rsp_valid_ff, rsp_valid_in;
   stidi_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [stidi_pkg::DATA_W-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [stidi_pkg::DATA_W-1:0] rd_data;

   logic [CW-1:0] idx_m1;
   logic [CW-1:0] idx_m2;
   logic match;

   assign idx_m1 = idx_ff - CW'(1);
   assign idx_m2 = idx_ff - CW'(2);

   stidi_ram #(
      .WIDTH(stidi_pkg::DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // sequencer: scans and shifts the table one entry per cycle
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = key_ff;
      rd_addr       = '0;
      match         = 1'b0;

      // response taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in       = req_data.value;
               idx_in       = '0;
               pend_in      = 1'b0;
               found_in     = 1'b0;
               res_value_in = '0;
               case (req_data.op)
                  stidi_pkg::OP_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        res_status_in = stidi_pkg::ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS;
                     end
                  end
                  stidi_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = stidi_pkg::ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_DEL;
                     end
                  end
                  stidi_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        res_status_in = stidi_pkg::ST_EMPTY;
                        state_in      = S_DONE;
                     end else if (req_data.position == 5'd0 ||
                                  32'(req_data.position) > 32'(count_ff)) begin
                        res_status_in = stidi_pkg::ST_INVALID;
                        state_in      = S_DONE;
                     end else begin
                        rd_addr  = AW'(req_data.position - 5'd1);
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     res_status_in = stidi_pkg::ST_INVALID;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         // walk down from the top, moving larger entries up by one
         S_INS: begin
            if (pend_ff && key_ff < $signed(rd_data)) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = rd_data;
               idx_in  = idx_m1;
               if (idx_ff != CW'(1)) begin
                  rd_addr = idx_m2[AW-1:0];
               end else begin
                  pend_in = 1'b0;
               end
            end else if (!pend_ff && idx_ff != '0) begin
               rd_addr = idx_m1[AW-1:0];
               pend_in = 1'b1;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = idx_ff[AW-1:0];
               wr_data       = key_ff;
               count_in      = count_ff + CW'(1);
               res_status_in = stidi_pkg::ST_INSERTED;
               state_in      = S_DONE;
            end
         end

         // walk up, find the first match and close the gap behind it
         S_DEL: begin
            match = pend_ff && !found_ff && rd_data == key_ff;
            if (pend_ff && found_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_m2[AW-1:0];
               wr_data = rd_data;
            end
            found_in = found_ff | match;
            if (idx_ff < count_ff) begin
               rd_addr = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               if (found_ff || match) begin
                  count_in      = count_ff - CW'(1);
                  res_status_in = stidi_pkg::ST_DELETED;
               end else begin
                  res_status_in = stidi_pkg::ST_NOT_FOUND;
               end
               state_in = S_DONE;
            end
         end

         S_RD: begin
            res_value_in  = $signed(rd_data);
            res_status_in = stidi_pkg::ST_FOUND;
            state_in      = S_DONE;
         end

         // load the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.read_value  = res_value_ff;
               rsp_data_in.entry_count = 5'(count_ff);
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/stidi_chk.sv]
// Port-level checker for the sorted table block, bound to its top level.
// Depends on stidi_pkg and sorted_table_insert_delete_index.
module stidi_chk #(
   parameter int CAPACITY = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input stidi_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input stidi_pkg::rsp_type rsp_data
);

   // a stalled request stays
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // read data is zero unless an entry was found
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != stidi_pkg::ST_FOUND |-> rsp_data.read_value == '0)
      else $error("read value set without a found entry");

   // full only at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == stidi_pkg::ST_FULL |->
         rsp_data.entry_count == 5'(CAPACITY))
      else $error("full reported below capacity");

   // empty reports zero entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == stidi_pkg::ST_EMPTY |-> rsp_data.entry_count == 5'd0)
      else $error("empty reported with entries");

endmodule

bind sorted_table_insert_delete_index stidi_chk #(
   .CAPACITY(CAPACITY)
) u_stidi_chk (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
